// File: rtl/lcdns_pkg.sv
package lcdns_pkg;

    localparam logic [1:0] REQ_TEXT = 2'd0;
    localparam logic [1:0] REQ_CMD  = 2'd1;
    localparam logic [1:0] REQ_INIT = 2'd2;

    localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_BACKLIGHT_ON = 2'd1;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] BIT_BL       = 8'h08;
    localparam logic [7:0] BIT_RS       = 8'h01;

    localparam int unsigned STEP_W = 6;

    localparam logic [STEP_W-1:0] STEP_LINE2 = 6'd0;
    localparam logic [STEP_W-1:0] STEP_DATA  = 6'd4;
    localparam logic [STEP_W-1:0] STEP_INIT  = 6'd8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       text_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  expander_byte;
        logic        has_byte;
        logic [15:0] wait_us;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_DATA_HI,
        SRC_DATA_LO
    } t_src;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_IF_NL,
        FIN_ALWAYS
    } t_fin;

    typedef struct packed {
        t_src        src;
        logic [7:0]  byte_bits;
        logic        has_byte;
        logic [15:0] wait_us;
        t_fin        fin;
    } t_uword;

    typedef struct packed {
        logic busy;
        logic last;
    } t_seq_stat;

    function automatic t_uword uw(input t_src src, input logic [7:0] b,
                                  input logic has, input logic [15:0] w,
                                  input t_fin fin);
        t_uword u;
        u.src       = src;
        u.byte_bits = b;
        u.has_byte  = has;
        u.wait_us   = w;
        u.fin       = fin;
        return u;
    endfunction

    // Control store. Steps 0..3 send the second-line command, 4..7 send the
    // request's own byte, 8..35 are the power-up sequence.
    function automatic t_uword lcdns_rom(input logic [STEP_W-1:0] step);
        t_uword u;
        case (step)
            6'd0:    u = uw(SRC_CONST,   8'hC4, 1'b1, 16'd500,   FIN_NONE);
            6'd1:    u = uw(SRC_CONST,   8'hC0, 1'b1, 16'd100,   FIN_NONE);
            6'd2:    u = uw(SRC_CONST,   8'h04, 1'b1, 16'd500,   FIN_NONE);
            6'd3:    u = uw(SRC_CONST,   8'h00, 1'b1, 16'd100,   FIN_IF_NL);
            6'd4:    u = uw(SRC_DATA_HI, 8'h04, 1'b1, 16'd500,   FIN_NONE);
            6'd5:    u = uw(SRC_DATA_HI, 8'h00, 1'b1, 16'd100,   FIN_NONE);
            6'd6:    u = uw(SRC_DATA_LO, 8'h04, 1'b1, 16'd500,   FIN_NONE);
            6'd7:    u = uw(SRC_DATA_LO, 8'h00, 1'b1, 16'd100,   FIN_ALWAYS);
            6'd8:    u = uw(SRC_CONST,   8'h00, 1'b0, 16'd50000, FIN_NONE);
            6'd9:    u = uw(SRC_CONST,   8'h30, 1'b1, 16'd5000,  FIN_NONE);
            6'd10:   u = uw(SRC_CONST,   8'h34, 1'b1, 16'd500,   FIN_NONE);
            6'd11:   u = uw(SRC_CONST,   8'h30, 1'b1, 16'd5100,  FIN_NONE);
            6'd12:   u = uw(SRC_CONST,   8'h34, 1'b1, 16'd500,   FIN_NONE);
            6'd13:   u = uw(SRC_CONST,   8'h30, 1'b1, 16'd300,   FIN_NONE);
            6'd14:   u = uw(SRC_CONST,   8'h24, 1'b1, 16'd500,   FIN_NONE);
            6'd15:   u = uw(SRC_CONST,   8'h20, 1'b1, 16'd300,   FIN_NONE);
            6'd16:   u = uw(SRC_CONST,   8'h24, 1'b1, 16'd500,   FIN_NONE);
            6'd17:   u = uw(SRC_CONST,   8'h20, 1'b1, 16'd100,   FIN_NONE);
            6'd18:   u = uw(SRC_CONST,   8'h84, 1'b1, 16'd500,   FIN_NONE);
            6'd19:   u = uw(SRC_CONST,   8'h80, 1'b1, 16'd100,   FIN_NONE);
            6'd20:   u = uw(SRC_CONST,   8'h04, 1'b1, 16'd500,   FIN_NONE);
            6'd21:   u = uw(SRC_CONST,   8'h00, 1'b1, 16'd100,   FIN_NONE);
            6'd22:   u = uw(SRC_CONST,   8'h84, 1'b1, 16'd500,   FIN_NONE);
            6'd23:   u = uw(SRC_CONST,   8'h80, 1'b1, 16'd100,   FIN_NONE);
            6'd24:   u = uw(SRC_CONST,   8'h04, 1'b1, 16'd500,   FIN_NONE);
            6'd25:   u = uw(SRC_CONST,   8'h00, 1'b1, 16'd100,   FIN_NONE);
            6'd26:   u = uw(SRC_CONST,   8'h14, 1'b1, 16'd500,   FIN_NONE);
            6'd27:   u = uw(SRC_CONST,   8'h10, 1'b1, 16'd2100,  FIN_NONE);
            6'd28:   u = uw(SRC_CONST,   8'h04, 1'b1, 16'd500,   FIN_NONE);
            6'd29:   u = uw(SRC_CONST,   8'h00, 1'b1, 16'd100,   FIN_NONE);
            6'd30:   u = uw(SRC_CONST,   8'h64, 1'b1, 16'd500,   FIN_NONE);
            6'd31:   u = uw(SRC_CONST,   8'h60, 1'b1, 16'd100,   FIN_NONE);
            6'd32:   u = uw(SRC_CONST,   8'h04, 1'b1, 16'd500,   FIN_NONE);
            6'd33:   u = uw(SRC_CONST,   8'h00, 1'b1, 16'd100,   FIN_NONE);
            6'd34:   u = uw(SRC_CONST,   8'hC4, 1'b1, 16'd500,   FIN_NONE);
            6'd35:   u = uw(SRC_CONST,   8'hC0, 1'b1, 16'd100,   FIN_ALWAYS);
            default: u = uw(SRC_CONST,   8'h00, 1'b0, 16'd0,     FIN_ALWAYS);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/lcdns_seq.sv
module lcdns_seq
    import lcdns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [STEP_W-1:0] i_entry,
    input  logic              i_nl,
    input  logic              i_adv,
    output t_uword            o_uword,
    output t_seq_stat         o_stat
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_busy;
    logic              n_busy;
    t_uword            uword;
    logic              fin_now;

    assign uword = lcdns_rom(r_step);

    // A conditional finish ends the program early when the item was a newline.
    assign fin_now = (uword.fin == FIN_ALWAYS) || ((uword.fin == FIN_IF_NL) && i_nl);

    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        if (i_start) begin
            n_step = i_entry;
            n_busy = 1'b1;
        end else if (r_busy && i_adv) begin
            if (fin_now) begin
                n_busy = 1'b0;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_busy <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

    assign o_uword     = uword;
    assign o_stat.busy = r_busy;
    assign o_stat.last = fin_now;

endmodule

// File: rtl/char_lcd_nibble_sequencer.sv
// A taken item loads the step register; its first result then enters the output register.
// Throughput: one result per cycle when not stalled, from a 36-step control store; a text
// item gives 4 or 8 results, a raw command 4 and init 28, and the next item is taken at
// the edge after the one issuing the final step. Request type 3 is consumed with no results.
// Reset (synchronous, active low): idle, column 0, line width 16, backlight on.
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    logic [5:0]  r_line_width;
    logic        r_backlight;
    logic [5:0]  r_column;
    logic [5:0]  n_column;
    logic [7:0]  r_data;
    logic        r_rs;
    logic        r_nl;
    logic        r_out_valid;
    t_out_item   r_out;

    t_uword      uword;
    t_seq_stat   stat;
    logic        accept;
    logic        start;
    logic        adv;
    logic [STEP_W-1:0] entry;
    logic        is_nl;
    logic [5:0]  col0;
    logic        wrap;
    logic [3:0]  nib;
    logic [7:0]  step_byte;

    assign o_in_ready  = !stat.busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign adv         = !r_out_valid || i_out_ready;

    assign is_nl = (i_in.data_byte == CHAR_NEWLINE);
    assign col0  = i_in.text_start ? 6'd0 : r_column;
    assign wrap  = is_nl || (col0 >= r_line_width);

    // Entry point and column update are settled when the item is taken.
    always_comb begin
        start    = 1'b0;
        entry    = STEP_DATA;
        n_column = r_column;
        unique case (i_in.req_type)
            REQ_TEXT: begin
                start = accept;
                entry = wrap ? STEP_LINE2 : STEP_DATA;
                if (accept) begin
                    n_column = is_nl ? 6'd0 : ((wrap ? 6'd0 : col0) + 6'd1);
                end
            end
            REQ_CMD: begin
                start = accept;
                entry = STEP_DATA;
            end
            REQ_INIT: begin
                start = accept;
                entry = STEP_INIT;
            end
            default: begin
                start = 1'b0;
            end
        endcase
    end

    lcdns_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_entry (entry),
        .i_nl    (r_nl),
        .i_adv   (adv),
        .o_uword (uword),
        .o_stat  (stat)
    );

    assign nib = (uword.src == SRC_DATA_HI) ? r_data[7:4] : r_data[3:0];

    always_comb begin
        if (uword.src == SRC_CONST) begin
            step_byte = uword.byte_bits;
        end else begin
            step_byte = {nib, 4'b0000} | uword.byte_bits | (r_rs ? BIT_RS : 8'h00);
        end
        if (uword.has_byte) begin
            step_byte = step_byte | (r_backlight ? BIT_BL : 8'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= 6'd16;
            r_backlight  <= 1'b1;
            r_column     <= 6'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_LINE_WIDTH) begin
                    r_line_width <= i_cfg_data;
                end else if (i_cfg_index == CFG_BACKLIGHT_ON) begin
                    r_backlight <= i_cfg_data[0];
                end
            end
            r_column <= n_column;
            if (stat.busy && adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_data <= i_in.data_byte;
            r_rs   <= (i_in.req_type == REQ_TEXT);
            r_nl   <= (i_in.req_type == REQ_TEXT) && is_nl;
        end
        if (stat.busy && adv) begin
            r_out.expander_byte <= step_byte;
            r_out.has_byte      <= uword.has_byte;
            r_out.wait_us       <= uword.wait_us;
            r_out.last          <= stat.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
